// ===== design/gbsp_pkg.sv =====
// Shared types, constants and the exponential table of the gap-based speed profile.
// Used by every module of the block; depends on nothing.
package gbsp_pkg;

    localparam int POS_W   = 26;
    localparam int SPEED_W = 18;
    localparam int STEP_W  = 7;
    localparam int KEPT_W  = 7;
    localparam int IDX_W   = 6;
    localparam int INC_W   = 16;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_STEP_MS = 1'd1;
    localparam logic [SPEED_W-1:0]   SPEED_LIMIT_RST  = 18'd22528;
    localparam logic [STEP_W-1:0]    LEAD_STEP_RST    = 7'd20;

    // Gap offset of 30 m in Q.10, and speed change limits per step in LSB
    localparam logic [27:0] GAP_OFFSET = 28'd30720;
    localparam logic [11:0] DV_UP_MAX  = 12'd20;
    localparam logic [11:0] DV_DN_MAX  = 12'd102;

    // Reciprocals for constant division: q0 = (n * RCP) >> K, then one correction
    localparam logic [31:0] RCP_1000 = 32'd2199023255;
    localparam int          K_1000   = 41;
    localparam logic [18:0] RCP_250  = 19'd268435;
    localparam int          K_250    = 26;
    localparam logic [19:0] RCP_100  = 20'd671088;
    localparam int          K_100    = 26;

    // Exponential table e^(-0.06*i), Q1.16; every entry past about 197 rounds to zero,
    // so 256 entries cover any table depth.
    localparam int ROM_SIZE = 256;
    localparam int ROM_AW   = 8;
    localparam int EXP_W    = 17;
    localparam logic [63:0] EXP_RATIO = 64'd4044847872;

    typedef logic [ROM_SIZE-1:0][EXP_W-1:0] exp_rom_t;

    function automatic exp_rom_t exp_rom_build();
        exp_rom_t    rom;
        logic [63:0] t;
        t = 64'h1_0000_0000;
        for (int i = 0; i < ROM_SIZE; i++) begin
            rom[i] = EXP_W'((t + 64'd32768) >> 16);
            t = (t * EXP_RATIO + 64'h8000_0000) >> 32;
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = exp_rom_build();

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [POS_W-1:0]   start_pos;
        logic [SPEED_W-1:0] ego_speed;
        logic [POS_W-1:0]   lead_pos;
        logic [SPEED_W-1:0] lead_speed;
        logic [KEPT_W-1:0]  kept_points;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0] planned_pos;
        logic [IDX_W-1:0] point_index;
        logic             last_point;
    } out_t;

    // One planning job handed from front to back
    typedef struct packed {
        logic [POS_W-1:0]   s_ego;
        logic [SPEED_W-1:0] v;
        logic [POS_W-1:0]   s_lead;
        logic [INC_W-1:0]   lead_inc;
        logic [IDX_W-1:0]   first_idx;
    } job_t;

endpackage

// ===== design/gbsp_queue.sv =====
// Short job queue between front and back of the speed profile block.
// Depends on gbsp_pkg for the job type and depth.
module gbsp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  gbsp_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output gbsp_pkg::job_t pop_job
);
    import gbsp_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push_fire, pop_fire;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Occupancy follows pushes and pops exactly
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == QCNT_W'($past(count_reg) + QCNT_W'($past(push_fire))
                                      - QCNT_W'($past(pop_fire))))
        else $error("queue count out of step with pushes and pops");

endmodule

// ===== design/gbsp_front.sv =====
// Front end: accepts requests, extrapolates the lead vehicle, builds planning jobs.
// Depends on gbsp_pkg for payload, job types and division constants.
module gbsp_front #(
    parameter int PATH_POINTS = 50
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  gbsp_pkg::in_t                  s_data,
    input  logic [gbsp_pkg::STEP_W-1:0]    lead_step_ms,
    output logic                           push_valid,
    input  logic                           push_ready,
    output gbsp_pkg::job_t                 push_job
);
    import gbsp_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_PROD  = 6'b000010,
        F_SCALE = 6'b000100,
        F_RECIP = 6'b001000,
        F_FIX   = 6'b010000,
        F_PUSH  = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;
    in_t          req_reg;
    logic [25:0]  prod_reg;
    logic [25:0]  num_inc_reg;
    logic [30:0]  num_start_reg;
    logic [57:0]  rcp_inc_reg;
    logic [62:0]  rcp_start_reg;
    job_t         job_reg, job_next;

    logic [5:0]   kept_m1;
    logic [16:0]  q_inc0;
    logic [21:0]  q_start0;
    logic [31:0]  r_inc, r_start;
    logic [16:0]  q_inc;
    logic [21:0]  q_start;
    logic [26:0]  lead_sum;

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_job   = job_reg;

    // kept of zero gives numerator 500, which divides to zero: no special path needed
    assign kept_m1 = (req_reg.kept_points == '0) ? 6'd0 : 6'(req_reg.kept_points - 7'd1);

    always_comb begin
        q_inc0   = rcp_inc_reg[57:K_1000];
        q_start0 = rcp_start_reg[62:K_1000];
        r_inc    = 32'(num_inc_reg) - 32'(q_inc0) * 32'd1000;
        r_start  = 32'(num_start_reg) - 32'(q_start0) * 32'd1000;
        q_inc    = (r_inc >= 32'd1000) ? q_inc0 + 1'b1 : q_inc0;
        q_start  = (r_start >= 32'd1000) ? q_start0 + 1'b1 : q_start0;
        lead_sum = {1'b0, req_reg.lead_pos} + 27'(q_start);
        job_next.s_ego     = req_reg.start_pos;
        job_next.v         = req_reg.ego_speed;
        job_next.s_lead    = lead_sum[26] ? POS_MAX : lead_sum[25:0];
        job_next.lead_inc  = q_inc[INC_W-1:0];
        job_next.first_idx = req_reg.kept_points[IDX_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                // drop requests that leave no point to plan
                if (s_valid && (int'(s_data.kept_points) < PATH_POINTS)) begin
                    state_next = F_PROD;
                end
            end
            F_PROD:  state_next = F_SCALE;
            F_SCALE: state_next = F_RECIP;
            F_RECIP: state_next = F_FIX;
            F_FIX:   state_next = F_PUSH;
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid) begin
            req_reg <= s_data;
        end
        if (state_reg == F_PROD) begin
            prod_reg <= 26'(req_reg.lead_speed) * 26'(lead_step_ms);
        end
        if (state_reg == F_SCALE) begin
            num_inc_reg   <= prod_reg + 26'd500;
            num_start_reg <= 31'(kept_m1) * 31'(prod_reg) + 31'd500;
        end
        if (state_reg == F_RECIP) begin
            rcp_inc_reg   <= 58'(num_inc_reg) * 58'(RCP_1000);
            rcp_start_reg <= 63'(num_start_reg) * 63'(RCP_1000);
        end
        if (state_reg == F_FIX) begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== design/gbsp_back.sv =====
// Back end: runs the per-point speed and position recurrence and holds the result word.
// Depends on gbsp_pkg for job and result types, the exponential table and reciprocals.
module gbsp_back #(
    parameter int PATH_POINTS     = 50,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  gbsp_pkg::job_t                pop_job,
    input  logic [gbsp_pkg::SPEED_W-1:0]  speed_limit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output gbsp_pkg::out_t                m_data
);
    import gbsp_pkg::*;

    typedef enum logic [7:0] {
        B_IDLE   = 8'b00000001,
        B_GAP    = 8'b00000010,
        B_INTERP = 8'b00000100,
        B_TGT    = 8'b00001000,
        B_DVMUL  = 8'b00010000,
        B_DVFIX  = 8'b00100000,
        B_ADVMUL = 8'b01000000,
        B_ADVFIX = 8'b10000000
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [POS_W-1:0]   s_ego_reg, s_lead_reg;
    logic [SPEED_W-1:0] v_reg, vn_reg, tgt_reg;
    logic [INC_W-1:0]   inc_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [EXP_W-1:0]   a_reg, b_reg, e_reg;
    logic [9:0]         frac_reg;
    logic               xpos_reg, neg_reg;
    logic [18:0]        magr_reg;
    logic [37:0]        p250_reg;
    logic [19:0]        sum_reg;
    logic [39:0]        p100_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    logic signed [27:0] x;
    logic [16:0]        rom_idx;
    logic [EXP_W-1:0]   ab_diff;
    logic [26:0]        ab_prod;
    logic [34:0]        tgt_prod;
    logic signed [19:0] diff;
    logic [18:0]        mag;
    logic [11:0]        q250_0, q250, dv_mag;
    logic [19:0]        r250;
    logic signed [19:0] vn_raw;
    logic [SPEED_W-1:0] vn;
    logic [13:0]        q100_0, adv;
    logic [19:0]        r100;
    logic [26:0]        ego_sum, lead_sum;
    logic [POS_W-1:0]   ego_new, lead_new;
    logic               out_free, load_out, last_pt;

    function automatic logic [EXP_W-1:0] rom_read(input logic [16:0] k);
        if (k < 17'(ROM_SIZE) && int'(k) < EXP_TABLE_DEPTH) begin
            return EXP_ROM[k[ROM_AW-1:0]];
        end
        return '0;
    endfunction

    assign pop_ready = (state_reg == B_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign load_out  = (state_reg == B_ADVFIX) && out_free;
    assign last_pt   = (idx_reg == IDX_W'(PATH_POINTS - 1));

    // Gap to the lead, offset by 30 m, split into table index and fraction
    always_comb begin
        x       = 28'(signed'({2'b00, s_lead_reg})) - 28'(signed'({2'b00, s_ego_reg}))
                  - signed'(GAP_OFFSET);
        rom_idx = {1'b0, x[25:10]};
    end

    // Interpolate the exponential and scale the speed reference
    always_comb begin
        ab_diff  = a_reg - b_reg;
        ab_prod  = 27'(ab_diff) * 27'(frac_reg);
        tgt_prod = 35'(speed_limit) * 35'(EXP_W'(18'h10000 - 18'(e_reg)));
    end

    // Speed step: round |target - v| / 250, limit, then clamp the new speed
    always_comb begin
        diff    = signed'({2'b00, tgt_reg}) - signed'({2'b00, v_reg});
        mag     = diff[19] ? 19'(-diff) : 19'(diff);
        q250_0  = p250_reg[37:K_250];
        r250    = 20'(magr_reg) - 20'(q250_0) * 20'd250;
        q250    = (r250 >= 20'd250) ? q250_0 + 1'b1 : q250_0;
        if (neg_reg) begin
            dv_mag = (q250 > DV_DN_MAX) ? DV_DN_MAX : q250;
            vn_raw = signed'({2'b00, v_reg}) - signed'(20'(dv_mag));
        end else begin
            dv_mag = (q250 > DV_UP_MAX) ? DV_UP_MAX : q250;
            vn_raw = signed'({2'b00, v_reg}) + signed'(20'(dv_mag));
        end
        if (vn_raw < 0) begin
            vn = '0;
        end else if (vn_raw > signed'({2'b00, speed_limit})) begin
            vn = speed_limit;
        end else begin
            vn = vn_raw[SPEED_W-1:0];
        end
    end

    // Position advance: trapezoid for ego, fixed step for the lead, both saturating
    always_comb begin
        q100_0   = p100_reg[39:K_100];
        r100     = sum_reg - 20'(q100_0) * 20'd100;
        adv      = (r100 >= 20'd100) ? q100_0 + 1'b1 : q100_0;
        ego_sum  = {1'b0, s_ego_reg} + 27'(adv);
        lead_sum = {1'b0, s_lead_reg} + 27'(inc_reg);
        ego_new  = ego_sum[26] ? POS_MAX : ego_sum[POS_W-1:0];
        lead_new = lead_sum[26] ? POS_MAX : lead_sum[POS_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    state_next = B_GAP;
                end
            end
            B_GAP:    state_next = B_INTERP;
            B_INTERP: state_next = B_TGT;
            B_TGT:    state_next = B_DVMUL;
            B_DVMUL:  state_next = B_DVFIX;
            B_DVFIX:  state_next = B_ADVMUL;
            B_ADVMUL: state_next = B_ADVFIX;
            B_ADVFIX: begin
                if (out_free) begin
                    state_next = last_pt ? B_IDLE : B_GAP;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    s_ego_reg  <= pop_job.s_ego;
                    v_reg      <= pop_job.v;
                    s_lead_reg <= pop_job.s_lead;
                    inc_reg    <= pop_job.lead_inc;
                    idx_reg    <= pop_job.first_idx;
                end
            end
            B_GAP: begin
                xpos_reg <= !x[27] && (x != '0);
                a_reg    <= rom_read(rom_idx);
                b_reg    <= rom_read(rom_idx + 17'd1);
                frac_reg <= x[9:0];
            end
            B_INTERP: begin
                e_reg <= a_reg - ab_prod[26:10];
            end
            B_TGT: begin
                tgt_reg <= xpos_reg ? tgt_prod[33:16] : '0;
            end
            B_DVMUL: begin
                neg_reg  <= diff[19];
                magr_reg <= mag + 19'd125;
                p250_reg <= 38'(mag + 19'd125) * 38'(RCP_250);
            end
            B_DVFIX: begin
                vn_reg  <= vn;
                sum_reg <= 20'(v_reg) + 20'(vn) + 20'd50;
            end
            B_ADVMUL: begin
                p100_reg <= 40'(sum_reg) * 40'(RCP_100);
            end
            B_ADVFIX: begin
                if (out_free) begin
                    s_ego_reg              <= ego_new;
                    s_lead_reg             <= lead_new;
                    v_reg                  <= vn_reg;
                    idx_reg                <= idx_reg + 1'b1;
                    m_data_reg.planned_pos <= ego_new;
                    m_data_reg.point_index <= idx_reg;
                    m_data_reg.last_point  <= last_pt;
                end
            end
            default: begin
            end
        endcase
    end

    // The point counter never runs past the end of the path
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != B_IDLE) |-> (idx_reg <= IDX_W'(PATH_POINTS - 1)))
        else $error("point index beyond path end");

    // A new speed never exceeds the reference speed
    a_speed_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_ADVMUL) |-> (vn_reg <= speed_limit))
        else $error("planned speed above speed limit");

    // While a non-final point waits at the output, the job is still in progress
    a_job_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.last_point) |-> (state_reg != B_IDLE))
        else $error("back end idle before the last point of a job");

endmodule

// ===== design/gap_based_speed_profile_top.sv =====
// Top level of the gap-based speed profile planner: configuration registers and the
// front / queue / back chain. Depends on gbsp_pkg, gbsp_front, gbsp_queue, gbsp_back.
//
//   channel   direction  handshake          word
//   s_        in         s_valid/s_ready    gbsp_pkg::in_t  (one planning request)
//   m_        out        m_valid/m_ready    gbsp_pkg::out_t (one planned point)
//   cfg_      in         cfg_we             cfg_index selects, cfg_wdata carries the value
//
// Each request yields PATH_POINTS - kept_points result words; the loop-carried
// speed/position recurrence in the back end (lookup, interpolate, scale, speed step,
// position advance) finishes each word before it starts on the next. The front end
// takes a request after pushing its last job and runs ahead through a two-entry queue.
// Reset is synchronous, active low: it clears control state and loads register defaults.
// A stalled m_ready holds the back end at its last step; the queue fills meanwhile.
module gap_based_speed_profile_top #(
    parameter int PATH_POINTS     = 50,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gbsp_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output gbsp_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  logic [gbsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbsp_pkg::SPEED_W-1:0]    cfg_wdata
);
    import gbsp_pkg::*;

    logic [SPEED_W-1:0] speed_limit_reg;
    logic [STEP_W-1:0]  lead_step_reg;

    logic push_valid, push_ready, pop_valid, pop_ready;
    job_t push_job, pop_job;

    // Configuration: to be written only while idle (the block does not enforce this), so read directly by both halves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg <= SPEED_LIMIT_RST;
            lead_step_reg   <= LEAD_STEP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SPEED_LIMIT:  speed_limit_reg <= cfg_wdata;
                CFG_LEAD_STEP_MS: lead_step_reg   <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept, drop requests with nothing to plan, extrapolate the lead vehicle
    gbsp_front #(
        .PATH_POINTS (PATH_POINTS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .lead_step_ms (lead_step_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_job     (push_job)
    );

    // Hold jobs so the front can run ahead of a stalled back end
    gbsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back: advance speed and position point by point, drive the result register
    gbsp_back #(
        .PATH_POINTS     (PATH_POINTS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_job     (pop_job),
        .speed_limit (speed_limit_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== bench/gap_based_speed_profile_top_test.sv =====
// Self-checking bench for gap_based_speed_profile_top: planning requests in, planned points out.
// Holds its own speed-profile predictor and exponential table; depends on gbsp_pkg and the RTL.
module gap_based_speed_profile_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbsp_pkg::*;

    localparam int     PATH_LEN      = 50;
    localparam int     EXP_DEPTH     = 256;
    localparam int     SETTLE_CYCLES = 60;
    localparam int     REPORT_CAP    = 100;
    localparam longint POS_CEIL      = (longint'(1) << POS_W) - 1;
    localparam longint GAP_Q10       = 30 * 1024;   // 30 m, at or below which the target is 0
    localparam longint DV_DIVISOR    = 250;         // 0.2 * 0.02 s folded into one divide
    localparam longint DV_RISE_MAX   = 20;          // 1 m/s^2 over 20 ms
    localparam longint DV_FALL_MAX   = 102;         // 5 m/s^2 over 20 ms
    localparam longint EXP_ONE       = 65536;
    localparam longint Q10_MASK      = 1023;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_t                  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_t                 m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SPEED_LIMIT;
    logic [SPEED_W-1:0]   cfg_wdata = '0;

    // Predictor copies of the two registers
    logic [SPEED_W-1:0]   limit_speed;
    logic [STEP_W-1:0]    lead_step;

    longint               exp_table[EXP_DEPTH];
    out_t                 expected_points[$];
    int                   mismatches     = 0;
    bit                   sender_idles   = 1'b0;
    bit                   receiver_idles = 1'b0;
    int                   hold_request   = 0;
    int                   hold_count     = 0;
    int                   ready_gap      = 0;

    gap_based_speed_profile_top #(
        .PATH_POINTS     (PATH_LEN),
        .EXP_TABLE_DEPTH (EXP_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run, including every stall at its longest
    initial begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Build e^(-0.06*i) in Q1.16 by a Q32 recurrence, rounding at every step
    function automatic void build_exp_table();
        longint unsigned acc;
        acc = 64'h1_0000_0000;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            exp_table[i] = longint'((acc + 64'd32768) >> 16);
            acc = (acc * 64'd4044847872 + 64'h8000_0000) >> 32;
        end
    endfunction

    // Entries past the end of the table read as zero
    function automatic longint exp_entry(longint idx);
        if (idx < 0 || idx >= EXP_DEPTH)
            return 0;
        return exp_table[idx];
    endfunction

    function automatic longint clamp_pos(longint p);
        return (p > POS_CEIL) ? POS_CEIL : p;
    endfunction

    // Target speed from the gap: vref * (1 - e^(-0.06 * (gap - 30 m))), linear interpolation
    function automatic longint gap_target(longint gap, longint vref);
        longint x, idx, frac, a, b, e;
        x = gap - GAP_Q10;
        if (x <= 0)
            return 0;
        idx  = x >>> 10;
        frac = x & Q10_MASK;
        a    = exp_entry(idx);
        b    = exp_entry(idx + 1);
        e    = a - (((a - b) * frac) >>> 10);
        return (vref * (EXP_ONE - e)) >>> 16;
    endfunction

    // Work out every point that one request plans and queue it for the checker
    function automatic void plan_points(in_t req);
        longint pos_ego, v, pos_lead, lead_v, kept, vref, step, lead_inc;
        longint target, diff, mag, dv, vn;
        out_t   pt;
        pos_ego  = longint'(req.start_pos);
        v        = longint'(req.ego_speed);
        pos_lead = longint'(req.lead_pos);
        lead_v   = longint'(req.lead_speed);
        kept     = longint'(req.kept_points);
        vref     = longint'(limit_speed);
        step     = longint'(lead_step);
        lead_inc = (lead_v * step + 500) / 1000;
        // Carry the lead vehicle forward over the kept points, less one
        if (kept >= 1)
            pos_lead = clamp_pos(pos_lead + ((kept - 1) * lead_v * step + 500) / 1000);
        for (longint i = kept; i < PATH_LEN; i++) begin
            target = gap_target(pos_lead - pos_ego, vref);
            diff   = target - v;
            mag    = (diff < 0) ? -diff : diff;
            dv     = (mag + DV_DIVISOR / 2) / DV_DIVISOR;
            if (diff < 0)
                dv = -dv;
            if (dv > DV_RISE_MAX)
                dv = DV_RISE_MAX;
            if (dv < -DV_FALL_MAX)
                dv = -DV_FALL_MAX;
            vn = v + dv;
            if (vn > vref)
                vn = vref;
            if (vn < 0)
                vn = 0;
            pos_ego  = clamp_pos(pos_ego + (v + vn + 50) / 100);
            pos_lead = clamp_pos(pos_lead + lead_inc);
            v        = vn;
            pt.planned_pos = POS_W'(pos_ego);
            pt.point_index = IDX_W'(i);
            pt.last_point  = (i == PATH_LEN - 1);
            expected_points = {expected_points, pt};
        end
    endfunction

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, otherwise a random pause that is now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function automatic in_t make_request(longint start, longint ego, longint lead,
                                         longint lead_v, longint kept);
        in_t req;
        req.start_pos   = POS_W'(start);
        req.ego_speed   = SPEED_W'(ego);
        req.lead_pos    = POS_W'(lead);
        req.lead_speed  = SPEED_W'(lead_v);
        req.kept_points = KEPT_W'(kept);
        return req;
    endfunction

    // Mostly plausible traffic with the lead placed in each gap regime; some pure noise
    function automatic in_t random_request();
        in_t    req;
        longint start, gap, lead;
        int     pick;
        int     k;
        if ($urandom_range(0, 9) == 0) begin
            req.start_pos   = POS_W'($urandom);
            req.ego_speed   = SPEED_W'($urandom);
            req.lead_pos    = POS_W'($urandom);
            req.lead_speed  = SPEED_W'($urandom);
            req.kept_points = KEPT_W'($urandom_range(0, 64));
            return req;
        end
        if ($urandom_range(0, 9) == 0)
            start = POS_CEIL - longint'($urandom_range(0, 300000));
        else
            start = longint'(POS_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            gap = longint'($urandom_range(0, 36 * 1024)) - 6 * 1024;     // close or behind
        else if (pick < 70)
            gap = GAP_Q10 + longint'($urandom_range(0, 260 * 1024));     // mostly inside the table
        else
            gap = longint'($urandom_range(286 * 1024, 4000 * 1024));     // past the table
        lead = start + gap;
        if (lead < 0)
            lead = 0;
        lead = clamp_pos(lead);
        // Keep most paths short so long stalls do not dominate the run
        k = $urandom_range(0, 99);
        req.start_pos   = POS_W'(start);
        req.ego_speed   = ($urandom_range(0, 6) == 0) ? SPEED_W'($urandom)
                                                      : SPEED_W'($urandom_range(0, 30 * 1024));
        req.lead_pos    = POS_W'(lead);
        req.lead_speed  = ($urandom_range(0, 6) == 0) ? SPEED_W'($urandom)
                                                      : SPEED_W'($urandom_range(0, 40 * 1024));
        req.kept_points = (k < 60) ? KEPT_W'($urandom_range(35, 64))
                        : (k < 90) ? KEPT_W'($urandom_range(0, 34))
                        :            KEPT_W'($urandom_range(0, 64));
        return req;
    endfunction

    // Offer one request word and hold it until taken; valid stays high on return
    task automatic send_request(in_t req);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do
            @(posedge aclk);
        while (!s_ready);
        plan_points(req);
    endtask

    // Drop valid, drain every expected point, then cover requests that yield none
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SPEED_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SPEED_LIMIT)
            limit_speed = value;
        else
            lead_step = STEP_W'(value);
        @(posedge aclk);
    endtask

    task automatic send_random(int count);
        repeat (count) send_request(random_request());
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Randomize m_ready; a hold request from a test overrides everything for its length
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_count   = hold_request;
            hold_request = 0;
        end
        if (hold_count > 0) begin
            hold_count--;
            m_ready <= 1'b0;
        end else begin
            if (ready_gap == 0 && receiver_idles && $urandom_range(0, 3) == 0)
                ready_gap = pick_gap();
            if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare every accepted point word with the oldest prediction
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected word pos=%0d index=%0d last=%0d",
                                m_data.planned_pos, m_data.point_index, m_data.last_point));
            end else begin
                want = expected_points.pop_front();
                if (m_data.planned_pos !== want.planned_pos)
                    report_mismatch($sformatf("planned_pos index %0d: got %0d want %0d",
                                    want.point_index, m_data.planned_pos, want.planned_pos));
                if (m_data.point_index !== want.point_index)
                    report_mismatch($sformatf("point_index: got %0d want %0d",
                                    m_data.point_index, want.point_index));
                if (m_data.last_point !== want.last_point)
                    report_mismatch($sformatf("last_point index %0d: got %0d want %0d",
                                    want.point_index, m_data.last_point, want.last_point));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and every named corner under the reset register values
    task automatic test_directed();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_request(make_request(0, 0, 0, 0, 0));                       // zero gap: stop
        send_request(make_request(0, 0, 1000 * 1024, 20 * 1024, 0));    // far lead: speed up
        send_request(make_request(0, 262143, 2000 * 1024, 0, 45));      // ego over the limit
        send_request(make_request(100000, 10240, 100000 + GAP_Q10, 0, 40));      // exactly 30 m
        send_request(make_request(100000, 10240, 100000 + GAP_Q10 + 1, 0, 40));  // one LSB over
        send_request(make_request(5000, 15000, 5000 + 102912, 12000, 30));       // mid table
        send_request(make_request(0, 20000, GAP_Q10 + 255 * 1024, 0, 44));       // table end
        send_request(make_request(0, 20000, GAP_Q10 + 256 * 1024 + 7, 0, 44));   // just past
        send_request(make_request(500 * 1024, 22528, 100 * 1024, 5000, 40));    // lead behind
        send_request(make_request(POS_CEIL - 5000, 22528, POS_CEIL, 262143, 20)); // saturate
        send_request(make_request(POS_CEIL, 262143, POS_CEIL, 262143, 45));
        send_request(make_request(1234, 3000, 60 * 1024, 262143, 1));   // no start carry
        send_request(make_request(0, 8000, 0, 262143, 48));             // large start carry
        send_request(make_request(7777, 9999, 200 * 1024, 4096, 49));  // single last point
        send_request(make_request(7777, 9999, 200 * 1024, 4096, 50));   // nothing planned
        send_request(make_request(POS_CEIL, 262143, POS_CEIL, 262143, 64));
        send_request(make_request(0, 0, 0, 0, 63));
        settle();
    endtask

    task automatic test_speed_limit_extremes();
        write_register(CFG_SPEED_LIMIT, '0);
        send_request(make_request(0, 20000, 1000 * 1024, 0, 30));   // ego above a zero limit
        send_random(4);
        settle();
        write_register(CFG_SPEED_LIMIT, {SPEED_W{1'b1}});
        send_request(make_request(0, 0, 4000 * 1024, 0, 0));        // run toward the top speed
        send_random(4);
        settle();
        write_register(CFG_SPEED_LIMIT, SPEED_LIMIT_RST);
    endtask

    // Legal step extremes, then a still lead and the widest value the register holds
    task automatic test_lead_step_extremes();
        logic [SPEED_W-1:0] steps[4];
        steps = '{SPEED_W'(1), SPEED_W'(100), SPEED_W'(0), SPEED_W'(127)};
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        foreach (steps[i]) begin
            write_register(CFG_LEAD_STEP_MS, steps[i]);
            send_request(make_request(0, 10000, 40 * 1024, 262143, 30));
            send_random(3);
            settle();
        end
        write_register(CFG_LEAD_STEP_MS, SPEED_W'(LEAD_STEP_RST));
    endtask

    // Hold off the receiver long enough that the queue fills and s_ready drops
    task automatic test_backpressure();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_request   = 600;
        for (int i = 0; i < 8; i++)
            send_request(make_request($urandom_range(0, 100000), $urandom_range(0, 25000),
                                      $urandom_range(100000, 400000), $urandom_range(0, 30000),
                                      $urandom_range(0, 10)));
        settle();
    endtask

    // Random traffic under a fresh register setting per phase; one phase runs flat out
    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            write_register(CFG_SPEED_LIMIT, ($urandom_range(0, 2) == 0)
                                            ? SPEED_W'($urandom)
                                            : SPEED_W'($urandom_range(10240, 40960)));
            write_register(CFG_LEAD_STEP_MS, SPEED_W'($urandom_range(1, 100)));
            sender_idles   = (phase != 2);
            receiver_idles = (phase != 2) && (phase != 4);
            send_random(72);
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        build_exp_table();
        limit_speed = SPEED_LIMIT_RST;
        lead_step   = LEAD_STEP_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_speed_limit_extremes();
        test_lead_step_extremes();
        test_backpressure();
        test_random();
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
